// ===== hdl/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants for the chained hash set
// Sizes of the bucket table and the node pool, and the front-to-back record.
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int MaxBuckets = 1024;
	localparam int PoolNodes  = 4096;
	localparam int BktW       = $clog2(MaxBuckets);
	localparam int NodeW      = $clog2(PoolNodes);
	localparam int CntW       = NodeW + 1;
	localparam int CfgW       = 11;
	localparam int KeyW       = 64;
	localparam logic [CfgW-1:0] CfgReset = CfgW'(97);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// one classified beat handed from the front to the back
	typedef struct packed {
		op_t             op;
		logic [KeyW-1:0] key;
		logic [BktW-1:0] bucket;
	} job_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_HEAD,
		BK_NODE,
		BK_CMP,
		BK_OUT
	} bk_state_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} fr_state_t;

endpackage

// ===== hdl/chs_front.sv =====
// ----------------------------------------------------------------------------
// chs_front: input stage
// Accept a beat and reduce |key| modulo the bucket count, one bit per cycle.
// ----------------------------------------------------------------------------
module chs_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [chs_pkg::KeyW-1:0]  key,
	input  logic [chs_pkg::CfgW-1:0]  bucket_count,
	output logic                      job_valid,
	input  logic                      job_stall,
	output chs_pkg::job_t             job
);

	localparam int KeyW = chs_pkg::KeyW;
	localparam int BktW = chs_pkg::BktW;
	localparam int BitW = $clog2(KeyW);

	chs_pkg::fr_state_t state_q, state_d;
	logic [KeyW-1:0]  key_q;
	logic [KeyW-1:0]  mag_q;
	logic [BktW:0]    rem_q;
	logic [BktW:0]    div_q;
	logic [BitW-1:0]  bit_q;
	chs_pkg::op_t     op_q;

	logic [BktW:0]    div_eff;
	logic [BktW+1:0]  shifted;
	logic [BktW+1:0]  diff;
	logic [KeyW-1:0]  mag_in;

	always_comb begin
		if (bucket_count == '0) begin
			div_eff = (BktW+1)'(1);
		end else if (32'(bucket_count) > 32'(chs_pkg::MaxBuckets)) begin
			div_eff = (BktW+1)'(chs_pkg::MaxBuckets);
		end else begin
			div_eff = (BktW+1)'(bucket_count);
		end
	end

	// the most negative key negates to itself; force its magnitude to zero
	always_comb begin
		if (key == {1'b1, {(KeyW-1){1'b0}}}) begin
			mag_in = '0;
		end else if (key[KeyW-1]) begin
			mag_in = -key;
		end else begin
			mag_in = key;
		end
	end

	assign shifted = {rem_q, mag_q[KeyW-1]};
	assign diff    = shifted - {1'b0, div_q};

	assign in_stall  = (state_q != chs_pkg::FR_IDLE);
	assign job_valid = (state_q == chs_pkg::FR_PUSH);
	assign job.op     = op_q;
	assign job.key    = key_q;
	assign job.bucket = rem_q[BktW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chs_pkg::FR_IDLE: begin
				if (in_valid) state_d = chs_pkg::FR_DIV;
			end
			chs_pkg::FR_DIV: begin
				if (bit_q == BitW'(KeyW-1)) state_d = chs_pkg::FR_PUSH;
			end
			chs_pkg::FR_PUSH: begin
				if (!job_stall) state_d = chs_pkg::FR_IDLE;
			end
			default: state_d = chs_pkg::FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chs_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == chs_pkg::FR_IDLE && in_valid) begin
			key_q <= key;
			mag_q <= mag_in;
			op_q  <= chs_pkg::op_t'(operation);
			div_q <= div_eff;
			rem_q <= '0;
			bit_q <= '0;
		end else if (state_q == chs_pkg::FR_DIV) begin
			// restoring division: shift in one dividend bit, subtract if it fits
			if (!diff[BktW+1]) begin
				rem_q <= diff[BktW:0];
			end else begin
				rem_q <= shifted[BktW:0];
			end
			mag_q <= {mag_q[KeyW-2:0], 1'b0};
			bit_q <= bit_q + BitW'(1);
		end
	end

endmodule

// ===== hdl/chs_queue.sv =====
// ----------------------------------------------------------------------------
// chs_queue: two-entry job queue
// Decouple the front from the back so each side stalls on its own.
// ----------------------------------------------------------------------------
module chs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_stall,
	input  chs_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_stall,
	output chs_pkg::job_t rd_job
);

	chs_pkg::job_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = slot_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wr_job;
	end

endmodule

// ===== hdl/chs_back.sv =====
// ----------------------------------------------------------------------------
// chs_back: table engine
// Carry out inserts and chain walks over the bucket table and node pool.
// ----------------------------------------------------------------------------
module chs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_stall,
	input  chs_pkg::job_t        job,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 found,
	output logic                 status
);

	localparam int BktW  = chs_pkg::BktW;
	localparam int NodeW = chs_pkg::NodeW;
	localparam int CntW  = chs_pkg::CntW;
	localparam int KeyW  = chs_pkg::KeyW;

	// bucket heads {valid, index}, emptied by a clearing pass after reset
	logic [NodeW:0]   head_mem [chs_pkg::MaxBuckets];
	logic [KeyW-1:0]  key_mem  [chs_pkg::PoolNodes];
	logic [NodeW:0]   next_mem [chs_pkg::PoolNodes];  // {valid, index}

	chs_pkg::bk_state_t state_q, state_d;
	chs_pkg::job_t    job_q;
	logic [CntW-1:0]  used_q;
	logic [BktW-1:0]  clr_q;
	logic [NodeW-1:0] cur_q;
	logic             cur_vld_q;
	logic [CntW-1:0]  steps_q;
	logic [NodeW:0]   head_rd_q;
	logic [KeyW-1:0]  key_rd_q;
	logic [NodeW:0]   next_rd_q;
	logic             found_q, status_q;

	logic take, full, walk_ok, ins;

	assign job_stall = (state_q != chs_pkg::BK_IDLE);
	assign take      = job_valid && (state_q == chs_pkg::BK_IDLE);
	assign full      = (used_q >= CntW'(chs_pkg::PoolNodes));
	assign ins       = (state_q == chs_pkg::BK_HEAD) && (job_q.op == chs_pkg::OP_INSERT) && !full;
	assign out_valid = (state_q == chs_pkg::BK_OUT);
	assign found     = found_q;
	assign status    = status_q;
	assign walk_ok   = cur_vld_q && ({1'b0, cur_q} < used_q) && (steps_q < used_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chs_pkg::BK_CLEAR: begin
				if (clr_q == BktW'(chs_pkg::MaxBuckets - 1)) state_d = chs_pkg::BK_IDLE;
			end
			chs_pkg::BK_IDLE: if (take) state_d = chs_pkg::BK_HEAD;
			chs_pkg::BK_HEAD: begin
				if (job_q.op == chs_pkg::OP_INSERT) state_d = chs_pkg::BK_OUT;
				else state_d = chs_pkg::BK_NODE;
			end
			chs_pkg::BK_NODE: begin
				if (walk_ok) state_d = chs_pkg::BK_CMP;
				else state_d = chs_pkg::BK_OUT;
			end
			chs_pkg::BK_CMP: begin
				if (key_rd_q == job_q.key) state_d = chs_pkg::BK_OUT;
				else state_d = chs_pkg::BK_NODE;
			end
			chs_pkg::BK_OUT: if (!out_stall) state_d = chs_pkg::BK_IDLE;
			default: state_d = chs_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chs_pkg::BK_CLEAR;
			used_q  <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == chs_pkg::BK_CLEAR) clr_q <= clr_q + BktW'(1);
			if (ins) used_q <= used_q + CntW'(1);
		end
	end

	// memories: one write port each, registered reads
	always_ff @(posedge clk) begin
		if (take) head_rd_q <= head_mem[job.bucket];
		if (state_q == chs_pkg::BK_CLEAR) begin
			head_mem[clr_q] <= '0;
		end else if (ins) begin
			head_mem[job_q.bucket] <= {1'b1, used_q[NodeW-1:0]};
		end
		if (ins) begin
			key_mem[used_q[NodeW-1:0]]  <= job_q.key;
			next_mem[used_q[NodeW-1:0]] <= head_rd_q;
		end
		if (state_q == chs_pkg::BK_NODE) begin
			key_rd_q  <= key_mem[cur_q];
			next_rd_q <= next_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q    <= job;
			found_q  <= 1'b0;
			status_q <= 1'b0;
		end
		unique case (state_q)
			chs_pkg::BK_HEAD: begin
				cur_q     <= head_rd_q[NodeW-1:0];
				cur_vld_q <= head_rd_q[NodeW];
				steps_q   <= '0;
				if (job_q.op == chs_pkg::OP_INSERT) status_q <= full;
			end
			chs_pkg::BK_CMP: begin
				if (key_rd_q == job_q.key) begin
					found_q <= 1'b1;
				end else begin
					// advance along the chain
					cur_vld_q <= next_rd_q[NodeW];
					cur_q     <= next_rd_q[NodeW-1:0];
					steps_q   <= steps_q + CntW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/chained_hash_set.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set: hash set of signed 64-bit keys with separate chaining
// Insert pushes a node onto its bucket's chain; lookup walks the chain.
// ----------------------------------------------------------------------------
// Input beats (in_valid / in_stall, operation, key): operation 0 inserts key,
// 1 looks it up. Output beats (out_valid / out_stall, found, status): one per
// request, in order; found 1 on a lookup hit, status 1 on an insert dropped
// because the node pool is full. bucket_count: write only while idle; 0 acts
// as 1 and values above 1024 act as 1024.
// The front accepts a beat, reduces |key| mod bucket_count by a restoring
// division, one step per key bit, and hands the job off. An insert reads
// its bucket head and answers; a lookup then reads and compares each
// visited node until a hit or the end of the chain. The front divides one
// key at a time; the two-entry queue lets the next key divide during a
// walk. Reset clears the node count, loads bucket_count with 97 and starts
// a clearing pass that empties all 1024 buckets before the first job.
// When out_stall is high the result beat holds and the stall backs up
// through the queue into in_stall.
// ----------------------------------------------------------------------------
module chained_hash_set (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic signed [chs_pkg::KeyW-1:0]  key,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found,
	output logic                             status,
	input  logic                             cfg_wr_en,
	input  logic [chs_pkg::CfgW-1:0]         cfg_wr_data
);

	logic [chs_pkg::CfgW-1:0] bucket_count_q;
	logic                     fq_valid, fq_stall, qb_valid, qb_stall;
	chs_pkg::job_t            fq_job, qb_job;

	// hold the bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= chs_pkg::CfgReset;
		end else if (cfg_wr_en) begin
			bucket_count_q <= cfg_wr_data;
		end
	end

	chs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.key          (key),
		.bucket_count (bucket_count_q),
		.job_valid    (fq_valid),
		.job_stall    (fq_stall),
		.job          (fq_job)
	);

	chs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_stall (fq_stall),
		.wr_job   (fq_job),
		.rd_valid (qb_valid),
		.rd_stall (qb_stall),
		.rd_job   (qb_job)
	);

	chs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_stall (qb_stall),
		.job       (qb_job),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.status    (status)
	);

endmodule
